// ===== rtl/utc_pkg.sv =====
// Shared types, constants and helper functions for the timestamp-to-calendar block.
`default_nettype none

package utc_pkg;

  // Calendar and clock constants
  localparam logic [11:0] EpochYear    = 12'd1970;
  localparam logic [11:0] LastYear     = 12'd2106;
  localparam logic [11:0] SkipLeapYear = 12'd2100;  // only century non-leap year in range
  localparam logic [2:0]  EpochWeekday = 3'd4;      // 1970-01-01 was a Thursday
  localparam logic [3:0]  LastMonth    = 4'd12;
  localparam logic [4:0]  MonthDaysMax = 5'd31;
  localparam logic [8:0]  YearDays     = 9'd365;
  localparam logic [8:0]  LeapYearDays = 9'd366;

  localparam logic [31:0] SecsPerDay  = 32'd86400;
  localparam logic [31:0] SecsPerHour = 32'd3600;
  localparam logic [31:0] SecsPerMin  = 32'd60;

  // Quotient widths of the three restoring divisions
  localparam int unsigned DayBits  = 16;  // max 49710 days
  localparam int unsigned HourBits = 5;   // 0..23
  localparam int unsigned MinBits  = 6;   // 0..59
  localparam int unsigned IdxW     = 4;   // covers bit index DayBits-1

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_DAY,
    OP_DIV_HOUR,
    OP_DIV_MIN,
    OP_YEAR,
    OP_MONTH,
    OP_FINISH
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [IdxW-1:0] idx;  // quotient bit under trial
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } status_t;

  // Gregorian leap rule, exact over 1970..2106
  function automatic logic is_leap(input logic [11:0] y);
    is_leap = (y[1:0] == 2'b00) && (y != SkipLeapYear);
  endfunction

  // Month lengths: 31,28/29,31,30,31,30,31,31,30,31,30,31
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    case (m)
      4'd2:                      month_len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   month_len = 5'd30;
      default:                   month_len = 5'd31;
    endcase
  endfunction

  function automatic logic [2:0] mod7(input logic [4:0] v);
    logic [4:0] r;
    r = v;
    for (int i = 0; i < 4; i++) begin
      if (r >= 5'd7) begin
        r = r - 5'd7;
      end
    end
    mod7 = r[2:0];
  endfunction

  function automatic logic [2:0] wd_add(input logic [2:0] a, input logic [2:0] b);
    logic [3:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    wd_add = s[2:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/utc_stamp_if.sv =====
// Input channel: one timestamp per beat.
`default_nettype none

interface utc_stamp_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

`default_nettype wire

// ===== rtl/utc_date_if.sv =====
// Output channel: one calendar date and time of day per beat.
`default_nettype none

interface utc_date_if;
  logic        valid;
  logic        ready;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [2:0]  weekday;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  modport source (output valid, output year, output month, output day_of_month,
                  output weekday, output hour, output minute, output second,
                  input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  input weekday, input hour, input minute, input second,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/utc_ctrl.sv =====
// Sequencer for the conversion: divisions, year and month walks, result hand-off.
`default_nettype none

module utc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire utc_pkg::status_t status_i,
  output utc_pkg::cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAY,
    ST_HOUR,
    ST_MIN,
    ST_YEARS,
    ST_MONTHS,
    ST_FINISH
  } state_e;

  state_e                     state_q, state_d;
  logic [utc_pkg::IdxW-1:0]   cnt_q, cnt_d;
  logic                       out_valid_q, out_valid_d;
  logic                       finish_ok;

  assign finish_ok   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_o.op  = utc_pkg::OP_NOP;
    cmd_o.idx = cnt_q;
    // a waiting result leaves once taken
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = utc_pkg::OP_LOAD;
          cnt_d    = utc_pkg::IdxW'(utc_pkg::DayBits - 1);
          state_d  = ST_DAY;
        end
      end
      ST_DAY: begin
        cmd_o.op = utc_pkg::OP_DIV_DAY;
        cnt_d    = cnt_q - utc_pkg::IdxW'(1);
        if (cnt_q == '0) begin
          cnt_d   = utc_pkg::IdxW'(utc_pkg::HourBits - 1);
          state_d = ST_HOUR;
        end
      end
      ST_HOUR: begin
        cmd_o.op = utc_pkg::OP_DIV_HOUR;
        cnt_d    = cnt_q - utc_pkg::IdxW'(1);
        if (cnt_q == '0) begin
          cnt_d   = utc_pkg::IdxW'(utc_pkg::MinBits - 1);
          state_d = ST_MIN;
        end
      end
      ST_MIN: begin
        cmd_o.op = utc_pkg::OP_DIV_MIN;
        cnt_d    = cnt_q - utc_pkg::IdxW'(1);
        if (cnt_q == '0) begin
          state_d = ST_YEARS;
        end
      end
      ST_YEARS: begin
        cmd_o.op = utc_pkg::OP_YEAR;
        if (status_i.year_done) begin
          state_d = ST_MONTHS;
        end
      end
      ST_MONTHS: begin
        cmd_o.op = utc_pkg::OP_MONTH;
        if (status_i.month_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (finish_ok) begin
          cmd_o.op    = utc_pkg::OP_FINISH;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output register never overwritten while a beat is still pending
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == utc_pkg::OP_FINISH) |-> finish_ok)
    else $error("result loaded over a pending beat");

  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.op == utc_pkg::OP_FINISH))
    else $error("result valid without a finish step");

  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=>
      (state_q == ST_DAY && cnt_q == utc_pkg::IdxW'(utc_pkg::DayBits - 1)))
    else $error("accepted beat did not start the day division");

endmodule

`default_nettype wire

// ===== rtl/utc_dp.sv =====
// Datapath: zone shift, shared restoring divider, year/month walk, result registers.
`default_nettype none

module utc_dp (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic signed [4:0] cfg_wdata_i,
  input  wire logic [31:0]      epoch_seconds_i,
  input  wire utc_pkg::cmd_t    cmd_i,
  output utc_pkg::status_t      status_o,
  output logic [11:0]           year_o,
  output logic [3:0]            month_o,
  output logic [4:0]            day_of_month_o,
  output logic [2:0]            weekday_o,
  output logic [4:0]            hour_o,
  output logic [5:0]            minute_o,
  output logic [5:0]            second_o
);

  // zone offset kept pre-scaled to seconds, wraps mod 2^32
  logic [31:0] zone_shift_q, zone_shift_d;
  logic [31:0] zone_ext;

  assign zone_ext     = {{27{cfg_wdata_i[4]}}, cfg_wdata_i};
  assign zone_shift_d = zone_ext * utc_pkg::SecsPerHour;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_shift_q <= '0;
    end else if (cfg_we_i) begin
      zone_shift_q <= zone_shift_d;
    end
  end

  logic [31:0]                 rem_q, rem_d;
  logic [utc_pkg::DayBits-1:0] days_q, days_d;
  logic [utc_pkg::HourBits-1:0] hour_q, hour_d;
  logic [utc_pkg::MinBits-1:0] min_q, min_d;
  logic [11:0]                 year_q, year_d;
  logic [3:0]                  month_q, month_d;
  logic [2:0]                  wd_q, wd_d;

  // shared compare/subtract step of the restoring divider
  logic [31:0] div_base, div_shift;
  logic        div_ge;

  always_comb begin
    case (cmd_i.op)
      utc_pkg::OP_DIV_HOUR: div_base = utc_pkg::SecsPerHour;
      utc_pkg::OP_DIV_MIN:  div_base = utc_pkg::SecsPerMin;
      default:              div_base = utc_pkg::SecsPerDay;
    endcase
  end

  assign div_shift = div_base << cmd_i.idx;
  assign div_ge    = (rem_q >= div_shift);

  logic       leap;
  logic [8:0] ylen;
  logic [4:0] mlen;

  assign leap = utc_pkg::is_leap(year_q);
  assign ylen = leap ? utc_pkg::LeapYearDays : utc_pkg::YearDays;
  assign mlen = utc_pkg::month_len(month_q, leap);

  assign status_o.year_done  = (days_q < utc_pkg::DayBits'(ylen));
  assign status_o.month_done = (days_q < utc_pkg::DayBits'(mlen)) ||
                               (month_q == utc_pkg::LastMonth);

  always_comb begin
    rem_d   = rem_q;
    days_d  = days_q;
    hour_d  = hour_q;
    min_d   = min_q;
    year_d  = year_q;
    month_d = month_q;
    wd_d    = wd_q;
    case (cmd_i.op)
      utc_pkg::OP_LOAD: begin
        rem_d   = epoch_seconds_i + zone_shift_q;
        days_d  = '0;
        hour_d  = '0;
        min_d   = '0;
        year_d  = utc_pkg::EpochYear;
        month_d = 4'd1;
        wd_d    = utc_pkg::EpochWeekday;
      end
      utc_pkg::OP_DIV_DAY: begin
        if (div_ge) rem_d = rem_q - div_shift;
        days_d = {days_q[utc_pkg::DayBits-2:0], div_ge};
      end
      utc_pkg::OP_DIV_HOUR: begin
        if (div_ge) rem_d = rem_q - div_shift;
        hour_d = {hour_q[utc_pkg::HourBits-2:0], div_ge};
      end
      utc_pkg::OP_DIV_MIN: begin
        if (div_ge) rem_d = rem_q - div_shift;
        min_d = {min_q[utc_pkg::MinBits-2:0], div_ge};
      end
      utc_pkg::OP_YEAR: begin
        if (!status_o.year_done) begin
          days_d = days_q - utc_pkg::DayBits'(ylen);
          year_d = year_q + 12'd1;
          // 365 = 1 mod 7, 366 = 2 mod 7
          wd_d   = utc_pkg::wd_add(wd_q, leap ? 3'd2 : 3'd1);
        end
      end
      utc_pkg::OP_MONTH: begin
        if (!status_o.month_done) begin
          days_d  = days_q - utc_pkg::DayBits'(mlen);
          month_d = month_q + 4'd1;
          wd_d    = utc_pkg::wd_add(wd_q, utc_pkg::mod7(mlen));
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    days_q  <= days_d;
    hour_q  <= hour_d;
    min_q   <= min_d;
    year_q  <= year_d;
    month_q <= month_d;
    wd_q    <= wd_d;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == utc_pkg::OP_FINISH) begin
      year_o         <= year_q;
      month_o        <= month_q;
      day_of_month_o <= days_q[4:0] + 5'd1;
      weekday_o      <= utc_pkg::wd_add(wd_q, utc_pkg::mod7(days_q[4:0]));
      hour_o         <= hour_q;
      minute_o       <= min_q;
      second_o       <= rem_q[5:0];
    end
  end

  a_year_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == utc_pkg::OP_MONTH) |->
      (year_q >= utc_pkg::EpochYear && year_q <= utc_pkg::LastYear))
    else $error("year walk left the representable range");

  a_finish_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == utc_pkg::OP_FINISH) |->
      (month_q >= 4'd1 && month_q <= utc_pkg::LastMonth &&
       days_q < utc_pkg::DayBits'(utc_pkg::MonthDaysMax) &&
       hour_q < utc_pkg::HourBits'(24) && rem_q < utc_pkg::SecsPerMin))
    else $error("conversion finished with fields out of range");

endmodule

`default_nettype wire

// ===== rtl/unix_time_to_calendar.sv =====
// Top level: Unix timestamp to Gregorian date, time of day and weekday.
`default_nettype none

// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 UTC into year,
// month, day of month, weekday (0 = Sunday), hour, minute and second. The
// zone offset register (signed whole hours, reset 0) is written through
// cfg_we_i/cfg_wdata_i; the user must write it only while the block is idle,
// which the block itself does not enforce. Offset*3600 is added to the
// stamp modulo 2^32, so small stamps with a negative offset land in 2106 and
// large ones with a positive offset land in early 1970.
// One stamp is converted at a time. After a beat is accepted the sequencer
// runs a 16-step restoring division by 86400, then 5 steps for the hour and
// 6 for the minute on one shared compare/subtract unit, then walks one year
// per cycle and one month per cycle, then loads the result register. The
// conversion time grows with the number of whole years past 1970 (0..136) and
// with the month (1..12), and is longest for December 2105. The result
// register frees the input side: the next stamp is taken while a finished
// result still waits for its beat, and a new result only waits if the
// previous one has not been taken by the time it is ready. Weekday is
// tracked mod 7 alongside the walk, starting from Thursday at the epoch.
module unix_time_to_calendar (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic signed [4:0] cfg_wdata_i,
  utc_stamp_if.sink              stamp_i,
  utc_date_if.source             date_o
);

  utc_pkg::cmd_t    cmd;
  utc_pkg::status_t status;
  logic             in_ready;
  logic             out_valid;

  utc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (stamp_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (date_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  utc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .epoch_seconds_i (stamp_i.epoch_seconds),
    .cmd_i           (cmd),
    .status_o        (status),
    .year_o          (date_o.year),
    .month_o         (date_o.month),
    .day_of_month_o  (date_o.day_of_month),
    .weekday_o       (date_o.weekday),
    .hour_o          (date_o.hour),
    .minute_o        (date_o.minute),
    .second_o        (date_o.second)
  );

  assign stamp_i.ready = in_ready;
  assign date_o.valid  = out_valid;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the Unix timestamp to calendar converter.
module testbench;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [2:0]  wday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_t;

  // one directed stamp; want is used only where typed is set
  typedef struct {
    logic signed [4:0] zone;
    logic [31:0]       stamp;
    bit                typed;
    cal_t              want;
  } probe_t;

  localparam int unsigned MonthDays[12]    = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int unsigned WeekdayShift[12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
  localparam int unsigned QuietLimit       = 4000;  // bound on cycles with no beat on either side
  localparam int unsigned PhaseBeats       = 155;
  localparam int unsigned NumProbes        = 23;
  localparam cal_t        NoDate           = '0;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic signed [4:0] cfg_wdata_i;

  utc_stamp_if stamp_if ();
  utc_date_if  date_if ();

  unix_time_to_calendar u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stamp_i     (stamp_if),
    .date_o      (date_if)
  );

  cal_t              pending_dates[$];
  logic signed [4:0] zone_hours;   // shadow of the offset register
  bit                gaps_on;
  int unsigned       errors;
  int unsigned       quiet_cycles;
  int unsigned       stall_left;

  // Extremes, leap-rule corners and wrap-around of the offset sum.
  probe_t directed_probes[NumProbes] = '{
    '{5'sd0,   32'd0,          1'b1, '{12'd1970, 4'd1,  5'd1,  3'd4, 5'd0,  6'd0,  6'd0}},
    '{5'sd0,   32'hFFFFFFFF,   1'b1, '{12'd2106, 4'd2,  5'd7,  3'd0, 5'd6,  6'd28, 6'd15}},
    '{5'sd0,   32'd946684799,  1'b1, '{12'd1999, 4'd12, 5'd31, 3'd5, 5'd23, 6'd59, 6'd59}},
    '{5'sd0,   32'd951782400,  1'b1, '{12'd2000, 4'd2,  5'd29, 3'd2, 5'd0,  6'd0,  6'd0}},
    '{5'sd0,   32'd4107456000, 1'b1, '{12'd2100, 4'd2,  5'd28, 3'd0, 5'd0,  6'd0,  6'd0}},
    '{5'sd0,   32'd4107542400, 1'b1, '{12'd2100, 4'd3,  5'd1,  3'd1, 5'd0,  6'd0,  6'd0}},
    '{5'sd0,   32'd86399,      1'b0, NoDate},
    '{5'sd0,   32'd86400,      1'b0, NoDate},
    '{5'sd0,   32'd31535999,   1'b0, NoDate},
    '{5'sd0,   32'd31536000,   1'b0, NoDate},
    '{5'sd0,   32'd68169600,   1'b0, NoDate},
    '{5'sd0,   32'h7FFFFFFF,   1'b0, NoDate},
    '{5'sd0,   32'h80000000,   1'b0, NoDate},
    '{5'sd0,   32'hAAAAAAAA,   1'b0, NoDate},
    '{5'sd0,   32'h55555555,   1'b0, NoDate},
    // most negative offset: small stamps land in 2106
    '{-5'sd16, 32'd0,          1'b0, NoDate},
    '{-5'sd16, 32'd57599,      1'b0, NoDate},
    '{-5'sd16, 32'd57600,      1'b0, NoDate},
    // most positive offset: top stamps land in 1970
    '{5'sd15,  32'hFFFFFFFF,   1'b0, NoDate},
    '{5'sd15,  32'hFFFF1AFF,   1'b0, NoDate},
    '{-5'sd12, 32'd43200,      1'b0, NoDate},
    '{5'sd14,  32'hFFFF3B1F,   1'b0, NoDate},
    '{5'sd1,   32'hFFFFF1EF,   1'b0, NoDate}
  };

  function automatic bit leap_year(input int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  // Calendar date, time of day and weekday of stamp shifted by zone hours.
  function automatic cal_t calendar_of(input logic [31:0] stamp, input logic signed [4:0] zone);
    logic [31:0] shifted;
    int unsigned days, secs, yr, mon, mlen, wy;
    cal_t        c;
    shifted = stamp + {{27{zone[4]}}, zone} * 32'd3600;  // wraps mod 2^32
    days = shifted / 32'd86400;
    secs = shifted % 32'd86400;
    yr = 1970;
    while (days >= (leap_year(yr) ? 366 : 365)) begin
      days -= leap_year(yr) ? 366 : 365;
      yr++;
    end
    mon  = 1;
    mlen = MonthDays[0];
    while (days >= mlen && mon < 12) begin
      days -= mlen;
      mon++;
      mlen = (mon == 2 && leap_year(yr)) ? 29 : MonthDays[mon-1];
    end
    // Sakamoto: Jan and Feb count with the previous year
    wy = (mon < 3) ? yr - 1 : yr;
    c.year   = 12'(yr);
    c.month  = 4'(mon);
    c.mday   = 5'(days + 1);
    c.wday   = 3'((wy + wy / 4 - wy / 100 + wy / 400 + WeekdayShift[mon-1] + days + 1) % 7);
    c.hour   = 5'(secs / 3600);
    c.minute = 6'((secs % 3600) / 60);
    c.second = 6'(secs % 60);
    return c;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_stamp(input logic [31:0] stamp, input bit typed, input cal_t want);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      stamp_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    stamp_if.valid         <= 1'b1;
    stamp_if.epoch_seconds <= stamp;
    do @(posedge clk_i); while (!stamp_if.ready);
    pending_dates.push_back(typed ? want : calendar_of(stamp, zone_hours));
    @(negedge clk_i);
  endtask

  // Hold off the sender until every outstanding date has come back.
  task automatic drain;
    stamp_if.valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_zone(input logic signed [4:0] zone);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= zone;
    zone_hours   = zone;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic check_field(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      errors++;
    end
  endtask

  // result side: random ready stalls while gaps are on
  always @(negedge clk_i) begin
    if (!gaps_on) begin
      stall_left = 0;
      date_if.ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      date_if.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 3);
      date_if.ready <= 1'b0;
    end else begin
      date_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cal_t want;
    if (rst_ni && date_if.valid && date_if.ready) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected date beat, expected none, got %0d-%0d-%0d %0d:%0d:%0d",
                 $time, date_if.year, date_if.month, date_if.day_of_month,
                 date_if.hour, date_if.minute, date_if.second);
        errors++;
      end else begin
        want = pending_dates.pop_front();
        check_field("year",         want.year,   date_if.year);
        check_field("month",        want.month,  date_if.month);
        check_field("day_of_month", want.mday,   date_if.day_of_month);
        check_field("weekday",      want.wday,   date_if.weekday);
        check_field("hour",         want.hour,   date_if.hour);
        check_field("minute",       want.minute, date_if.minute);
        check_field("second",       want.second, date_if.second);
      end
    end
  end

  // watchdog: too long with no beat on either side
  always @(posedge clk_i) begin
    if ((stamp_if.valid && stamp_if.ready) || (date_if.valid && date_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [31:0]       stamp;
    logic signed [4:0] zone;
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_wdata_i            = '0;
    stamp_if.valid         = 1'b0;
    stamp_if.epoch_seconds = '0;
    date_if.ready          = 1'b0;
    zone_hours             = '0;
    gaps_on                = 1'b1;
    errors                 = 0;
    quiet_cycles           = 0;
    stall_left             = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part; first rows rely on the reset offset
    for (int i = 0; i < NumProbes; i++) begin
      if (directed_probes[i].zone != zone_hours) begin
        drain();
        write_zone(directed_probes[i].zone);
      end
      send_stamp(directed_probes[i].stamp, directed_probes[i].typed, directed_probes[i].want);
    end

    // random phases, one offset each; the last one runs without gaps
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       zone = 5'sd3;
        1:       zone = -5'sd16;
        2:       zone = 5'sd15;
        3:       zone = -5'sd1;
        4:       zone = -5'sd12;
        5:       zone = 5'sd14;
        6:       zone = 5'($urandom_range(0, 31));
        default: zone = 5'sd0;
      endcase
      drain();
      write_zone(zone);
      gaps_on = (p != 7);
      for (int n = 0; n < PhaseBeats; n++) begin
        if (p != 7 && $urandom_range(0, 39) == 0) gaps_on = !gaps_on;
        if (p == 1 && n == 60) drain();
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: stamp = $urandom;
          // around midnight of a random day
          5, 6:          stamp = 32'($urandom_range(0, 49710)) * 32'd86400
                                 + 32'($urandom_range(0, 6)) - 32'd3;
          // near the bottom and top of the stamp range, where offsets wrap
          7:             stamp = $urandom_range(0, 200000);
          8:             stamp = 32'hFFFFFFFF - $urandom_range(0, 200000);
          default:       stamp = 32'($urandom_range(0, 1193046)) * 32'd3600
                                 + 32'($urandom_range(0, 1));
        endcase
        send_stamp(stamp, 1'b0, NoDate);
      end
    end

    stamp_if.valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
    // catch any stray beat after the last expected date
    repeat (250) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/utc_pkg.sv
rtl/utc_stamp_if.sv
rtl/utc_date_if.sv
rtl/utc_ctrl.sv
rtl/utc_dp.sv
rtl/unix_time_to_calendar.sv
verif/testbench.sv
